// File: rtl/core/lcg48_pkg.sv
package lcg48_pkg;

   localparam int unsigned StateWidth = 48;
   localparam int unsigned DrawWidth  = 31;
   localparam int unsigned BoundWidth = 32;

   localparam logic [StateWidth-1:0] LcgMult = 48'h0005_DEEC_E66D;
   localparam logic [StateWidth-1:0] LcgAdd  = 48'd11;

   // The multiplier constant is applied one 16-bit digit per cycle.
   localparam int unsigned DigitWidth = 16;
   localparam int unsigned MulDigits  = 3;
   localparam int unsigned DivSteps   = DrawWidth;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCALE,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } fsm_state_type;

   function automatic logic [DigitWidth-1:0] mult_digit(input logic [1:0] idx);
      logic [DigitWidth-1:0] digit;
      case (idx)
         2'd0:    digit = LcgMult[15:0];
         2'd1:    digit = LcgMult[31:16];
         default: digit = LcgMult[47:32];
      endcase
      return digit;
   endfunction

endpackage

// File: rtl/core/lcg48_bounded_random_unit.sv
// Bounded random number unit built on a 48-bit linear congruential generator.
// A request carries a signed 32-bit bound on req_bound; the response returns
// one integer in [0, bound) on rsp_value. A bound of zero or less returns 0
// without advancing the generator. Writing csr_wr_data with csr_wr_en high
// reseeds the generator with the seed XOR the multiplier; do this while idle.
// Both channels use valid/ready. One request is in flight at a time, and
// req_ready is low from acceptance until its result is moved to the output
// register. A generator step runs in the shared 48x16 multiplier.
// A power-of-two bound then goes through a scaling state that keeps the
// top bits of the draw times the bound. Any other bound goes through the
// bit-serial remainder unit and then the rejection test; a rejected draw
// repeats the generator step, the remainder and the test. A nonpositive
// bound goes straight to the response without a generator step.
// The output register lets a new request enter while a response waits; if
// the receiver stalls, the next result is held until the register frees up.
// Synchronous reset clears the handshakes and loads the generator state with
// the scrambled zero seed.
module lcg48_bounded_random_unit
   import lcg48_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [BoundWidth-1:0] req_bound,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [DrawWidth-1:0]        rsp_value,
   input  logic                        csr_wr_en,
   input  logic [StateWidth-1:0]       csr_wr_data
);

   fsm_state_type state_ff, state_in;

   logic [StateWidth-1:0] lcg_ff, lcg_in;
   logic [StateWidth-1:0] acc_ff, acc_in;
   logic [BoundWidth-1:0] bound_ff, bound_in;
   logic [DrawWidth-1:0]  draw_ff, draw_in;
   logic [DrawWidth-1:0]  div_shift_ff, div_shift_in;
   logic [BoundWidth-1:0] rem_ff, rem_in;
   logic [DrawWidth-1:0]  result_ff, result_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DrawWidth-1:0]  rsp_value_ff, rsp_value_in;

   logic                          req_nonpos;
   logic                          bound_pow2;
   logic                          mul_last;
   logic                          div_last;
   logic                          out_free;
   logic                          reject;
   logic [63:0]                   mul_prod;
   logic [StateWidth-1:0]         mul_shifted;
   logic [StateWidth-1:0]         acc_next;
   logic [BoundWidth-1:0]         rem_shift;
   logic [BoundWidth-1:0]         check_sum;
   logic [2*DrawWidth-1:0]        scale_prod;

   assign req_nonpos = req_bound[BoundWidth-1] || (req_bound == '0);
   assign bound_pow2 = ((bound_ff & (~bound_ff + 32'd1)) == bound_ff);
   assign mul_last   = (cnt_ff == 5'(MulDigits - 1));
   assign div_last   = (cnt_ff == 5'(DivSteps - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Shared multiplier: one digit of the constant against the full state.
   always_comb begin
      mul_prod = 64'(lcg_ff) * 64'(mult_digit(cnt_ff[1:0]));
      case (cnt_ff[1:0])
         2'd0:    mul_shifted = mul_prod[47:0];
         2'd1:    mul_shifted = {mul_prod[31:0], 16'd0};
         default: mul_shifted = {mul_prod[15:0], 32'd0};
      endcase
      acc_next = acc_ff + mul_shifted;
   end

   // Restoring remainder step, one dividend bit per cycle.
   assign rem_shift = {rem_ff[BoundWidth-2:0], div_shift_ff[DrawWidth-1]};

   // Rejection test in 32-bit wraparound arithmetic.
   assign check_sum = {1'b0, draw_ff} - {1'b0, rem_ff[DrawWidth-1:0]} + bound_ff - 32'd1;
   assign reject    = check_sum[BoundWidth-1];

   // For a power-of-two bound the product is the draw shifted by the position
   // of the bound's single set bit.
   always_comb begin
      scale_prod = '0;
      for (int i = 0; i < DrawWidth; i++) begin
         if (bound_ff[i]) begin
            scale_prod = scale_prod | ({{DrawWidth{1'b0}}, draw_ff} << i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_nonpos ? ST_FINISH : ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_last) begin
               state_in = bound_pow2 ? ST_SCALE : ST_DIV;
            end
         end
         ST_SCALE: state_in = ST_FINISH;
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = reject ? ST_MUL : ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lcg_in       = lcg_ff;
      acc_in       = acc_ff;
      bound_in     = bound_ff;
      draw_in      = draw_ff;
      div_shift_in = div_shift_ff;
      rem_in       = rem_ff;
      result_in    = result_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bound_in  = req_bound;
               result_in = '0;
               acc_in    = LcgAdd;
               cnt_in    = '0;
            end
         end
         ST_MUL: begin
            acc_in = acc_next;
            cnt_in = cnt_ff + 5'd1;
            if (mul_last) begin
               lcg_in       = acc_next;
               draw_in      = acc_next[StateWidth-1 -: DrawWidth];
               div_shift_in = acc_next[StateWidth-1 -: DrawWidth];
               rem_in       = '0;
               cnt_in       = '0;
            end
         end
         ST_SCALE: begin
            result_in = scale_prod[2*DrawWidth-1 -: DrawWidth];
         end
         ST_DIV: begin
            rem_in       = (rem_shift >= bound_ff) ? rem_shift - bound_ff : rem_shift;
            div_shift_in = {div_shift_ff[DrawWidth-2:0], 1'b0};
            cnt_in       = cnt_ff + 5'd1;
         end
         ST_CHECK: begin
            result_in = rem_ff[DrawWidth-1:0];
            acc_in    = LcgAdd;
            cnt_in    = '0;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_wr_en) begin
         lcg_in = csr_wr_data ^ LcgMult;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lcg_ff       <= LcgMult;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcg_ff       <= lcg_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      bound_ff     <= bound_in;
      draw_ff      <= draw_in;
      div_shift_ff <= div_shift_in;
      rem_ff       <= rem_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // The generator moves only at the end of a step or on a reseed.
   a_lcg_stable: assert property (@(posedge clock) disable iff (reset)
      (!csr_wr_en && !(state_ff == ST_MUL && mul_last)) |=> $stable(lcg_ff))
      else $error("generator state changed outside a step or reseed");

   a_rem_below_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (rem_ff < bound_ff))
      else $error("remainder not below bound");

   a_nonpos_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_nonpos) |=> (state_ff == ST_FINISH && result_ff == '0))
      else $error("nonpositive bound did not give zero");

   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not moved to output register");

endmodule
